@@ rtl/dsd_pkg.sv @@
// shared types, constants and functions of the scratchpad decoder
// no dependencies
package dsd_pkg;

  localparam int unsigned SCRATCH_LEN = 9;
  localparam int unsigned STORE_LEN   = 8;

  localparam logic [7:0] FAM_S20  = 8'h10;
  localparam logic [7:0] FAM_B20  = 8'h28;
  localparam logic [7:0] FAM_1822 = 8'h22;
  localparam logic [7:0] FAM_1825 = 8'h3B;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [7:0]  COUNTS_PER_DEG = 8'h10;
  localparam logic [15:0] S20_INT_MASK   = 16'hFFF0;
  localparam logic [15:0] S20_BIAS       = 16'd12;
  localparam logic signed [10:0] TEMP_SCALE = 11'sd625;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONNECT  = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_FAMILY   = 2'd3
  } dsd_status_t;

  // one decoded frame, handed from the front to the back
  typedef struct packed {
    dsd_status_t status;
    logic        s20;
    logic [1:0]  res_idx;
    logic        rewrite;
    logic [7:0]  code;
    logic [7:0]  temp_lsb;
    logic [7:0]  temp_msb;
    logic [7:0]  count_remain;
    logic [7:0]  counts_per_deg;
  } dsd_rec_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] res_code(input logic [1:0] idx);
    logic [7:0] code;
    case (idx)
      2'd0:    code = 8'h1F;
      2'd1:    code = 8'h3F;
      2'd2:    code = 8'h5F;
      2'd3:    code = 8'h7F;
      default: code = 8'h1F;
    endcase
    return code;
  endfunction

  function automatic logic [15:0] noise_mask(input logic [1:0] idx);
    logic [15:0] m;
    case (idx)
      2'd0:    m = 16'd7;
      2'd1:    m = 16'd3;
      2'd2:    m = 16'd1;
      2'd3:    m = 16'd0;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/dsd_if.sv @@
// valid/ready channel interfaces for scratchpad bytes and decoded results
// no dependencies
interface dsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scratch_byte;
  logic       last_byte;
  logic [7:0] family_code;
  logic [7:0] resolution;
  logic       presence_ok;

  modport source (output valid, scratch_byte, last_byte, family_code, resolution,
                  presence_ok, input ready);
  modport sink   (input valid, scratch_byte, last_byte, family_code, resolution,
                  presence_ok, output ready);
endinterface

interface dsd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [25:0] temperature;
  logic               rewrite_config;
  logic [7:0]         config_code;

  modport source (output valid, status, temperature, rewrite_config, config_code,
                  input ready);
  modport sink   (input valid, status, temperature, rewrite_config, config_code,
                  output ready);
endinterface

@@ rtl/dsd_front.sv @@
// front: takes scratchpad bytes, runs crc and zero check, classifies the frame
// depends on dsd_pkg
module dsd_front import dsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scratch_byte,
  input  logic       in_last_byte,
  input  logic [7:0] in_family_code,
  input  logic [7:0] in_resolution,
  input  logic       in_presence_ok,
  input  logic       q_full,
  output logic       q_push,
  output dsd_rec_t   q_rec
);

  logic [7:0] crc_r, crc_nxt;
  logic       any_r, any_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] store_r [STORE_LEN];
  logic       fire;
  logic [1:0] res_idx;
  logic       s20;
  logic [7:0] code;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign q_push   = fire && in_last_byte;

  assign crc_nxt = crc8_byte(crc_r, in_scratch_byte);
  assign any_nxt = any_r || (in_scratch_byte != 8'd0);
  assign idx_nxt = (idx_r < 4'd15) ? idx_r + 4'd1 : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      any_r <= 1'b0;
      idx_r <= '0;
    end else if (fire) begin
      if (in_last_byte) begin
        crc_r <= '0;
        any_r <= 1'b0;
        idx_r <= '0;
      end else begin
        crc_r <= crc_nxt;
        any_r <= any_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

  // the ninth byte is the crc itself and is never read back
  always_ff @(posedge clk) begin
    if (fire && idx_r < 4'(STORE_LEN)) begin
      store_r[idx_r[2:0]] <= in_scratch_byte;
    end
  end

  always_comb begin
    s20 = (in_family_code == FAM_S20);
    if (s20 || in_resolution < 8'd9) begin
      res_idx = 2'd0;
    end else if (in_resolution > 8'd12) begin
      res_idx = 2'd3;
    end else begin
      res_idx = 2'(in_resolution - 8'd9);
    end
    code = res_code(res_idx);
  end

  always_comb begin
    q_rec = '0;
    if (!in_presence_ok || !any_nxt) begin
      q_rec.status = ST_CONNECT;
    end else if (idx_nxt != 4'(SCRATCH_LEN) || crc_nxt != 8'd0) begin
      q_rec.status = ST_CHECKSUM;
    end else if (!(in_family_code inside {FAM_S20, FAM_B20, FAM_1822, FAM_1825})) begin
      q_rec.status = ST_FAMILY;
    end else begin
      q_rec.status         = ST_OK;
      q_rec.s20            = s20;
      q_rec.res_idx        = res_idx;
      q_rec.code           = code;
      q_rec.rewrite        = !s20 && (store_r[4] != code);
      q_rec.temp_lsb       = store_r[0];
      q_rec.temp_msb       = store_r[1];
      q_rec.count_remain   = store_r[6];
      q_rec.counts_per_deg = store_r[7];
    end
  end

`ifndef SYNTHESIS
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (idx_r == 4'd0 && crc_r == 8'd0 && !any_r))
    else $error("frame state not cleared after last byte");
`endif

endmodule

@@ rtl/dsd_queue.sv @@
// short fifo of decoded frame records between front and back
// depends on dsd_pkg
module dsd_queue import dsd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dsd_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output dsd_rec_t pop_rec
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dsd_rec_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count past depth");
`endif

endmodule

@@ rtl/dsd_back.sv @@
// back: builds the raw reading, scales it to 0.0001 degC, holds the result
// depends on dsd_pkg
module dsd_back import dsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  dsd_rec_t           q_rec,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [25:0] out_temperature,
  output logic               out_rewrite_config,
  output logic [7:0]         out_config_code
);

  // stage 1: raw reading
  logic        s1_valid_r;
  dsd_status_t s1_status_r;
  logic [15:0] s1_raw_r, raw_nxt;
  logic        s1_rewrite_r;
  logic [7:0]  s1_code_r;
  // stage 2: output register
  logic               o_valid_r;
  dsd_status_t        o_status_r;
  logic signed [25:0] o_temp_r;
  logic               o_rewrite_r;
  logic [7:0]         o_code_r;

  logic               s1_adv, s2_adv;
  logic [15:0]        raw16, s20_sh;
  logic signed [25:0] prod;

  assign s2_adv = s1_valid_r && (!o_valid_r || out_ready);
  assign s1_adv = !s1_valid_r || s2_adv;
  assign q_pop  = q_not_empty && s1_adv;

  always_comb begin
    raw16  = {q_rec.temp_msb, q_rec.temp_lsb};
    s20_sh = raw16 << 3;
    if (q_rec.s20) begin
      // count registers add the sub-degree part on the 9-bit family
      if (q_rec.counts_per_deg == COUNTS_PER_DEG) begin
        raw_nxt = (s20_sh & S20_INT_MASK) + S20_BIAS - {8'd0, q_rec.count_remain};
      end else begin
        raw_nxt = s20_sh;
      end
    end else begin
      raw_nxt = raw16 & ~noise_mask(q_rec.res_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_status_r  <= q_rec.status;
      s1_raw_r     <= raw_nxt;
      s1_rewrite_r <= q_rec.rewrite;
      s1_code_r    <= q_rec.code;
    end
  end

  // full product of a 16-bit reading and 625 fits in 26 signed bits
  assign prod = $signed(s1_raw_r) * TEMP_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s2_adv) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_status_r  <= s1_status_r;
      o_temp_r    <= prod;
      o_rewrite_r <= s1_rewrite_r;
      o_code_r    <= s1_code_r;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_status         = o_status_r;
  assign out_temperature    = o_temp_r;
  assign out_rewrite_config = o_rewrite_r;
  assign out_config_code    = o_code_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_status_r != ST_OK) |->
      (o_temp_r == '0 && !o_rewrite_r && o_code_r == 8'd0))
    else $error("error result carries nonzero fields");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> (s1_valid_r && $stable(s1_raw_r)))
    else $error("stage 1 lost or changed while blocked");
`endif

endmodule

@@ rtl/ds18x20_scratchpad_decoder_top.sv @@
// top level of the temperature sensor scratchpad decoder
// depends on dsd_pkg, dsd_if, dsd_front, dsd_queue, dsd_back
//
// usage:
//   in_ch carries one scratchpad byte per beat, byte 0 first; last_byte marks
//   the ninth. family_code, resolution and presence_ok are sampled with the
//   last byte. every beat with last_byte high yields one result on out_ch,
//   other beats yield none.
//   result: status (0 ok, 1 connect, 2 checksum, 3 family), temperature in
//   0.0001 degC, rewrite_config and config_code; on error all but status are 0.
// timing:
//   one byte per cycle sustained while the queue has room. out_valid for a last
//   byte rises once its record has passed the front classify into the queue,
//   the raw build into stage 1 and the 16x11 multiply into the output register.
//   the record queue holds QUEUE_DEPTH frames; when out_ready is low the back
//   stalls, the queue fills, and in_ready drops only once the queue is full.
// reset:
//   synchronous active low rst_n clears the crc, byte count, queue and all
//   valid flags; stored scratch bytes keep whatever they held.
module ds18x20_scratchpad_decoder_top import dsd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  dsd_in_if.sink   in_ch,
  dsd_out_if.source out_ch
);

  logic     q_full, q_push, q_pop, q_not_empty;
  dsd_rec_t push_rec, pop_rec;

  dsd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_scratch_byte (in_ch.scratch_byte),
    .in_last_byte    (in_ch.last_byte),
    .in_family_code  (in_ch.family_code),
    .in_resolution   (in_ch.resolution),
    .in_presence_ok  (in_ch.presence_ok),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_rec           (push_rec)
  );

  dsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (pop_rec)
  );

  dsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_rec              (pop_rec),
    .q_pop              (q_pop),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_temperature    (out_ch.temperature),
    .out_rewrite_config (out_ch.rewrite_config),
    .out_config_code    (out_ch.config_code)
  );

endmodule

@@ tb/sv/tb_ds18x20_scratchpad_decoder_top.sv @@
// testbench for ds18x20_scratchpad_decoder_top: random and directed scratchpad frames,
// results checked against a predictor of crc, frame checks and temperature decode
// depends on dsd_pkg, dsd_if and the decoder rtl
import dsd_pkg::*;

typedef struct packed {
  dsd_status_t        status;
  logic signed [25:0] temperature;
  logic               rewrite;
  logic [7:0]         cfg_code;
} decoded_t;

class scratch_check;
  logic [7:0] crc_acc;
  bit         seen_nonzero;
  logic [3:0] byte_cnt;
  logic [7:0] pad [9];
  decoded_t   expected_frames[$];
  int         mismatches;
  int         unexpected;
  int         frames_checked;
  int         status_seen [4];

  function new();
    crc_acc = 8'h00;
    seen_nonzero = 0;
    byte_cnt = 4'd0;
    mismatches = 0;
    unexpected = 0;
    frames_checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (pad[i]) pad[i] = 8'h00;
  endfunction

  // 1-wire crc, lsb first
  function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function void note_byte(logic [7:0] b, logic last, logic [7:0] fam, logic [7:0] req,
                          logic pres);
    decoded_t           exp_r;
    int                 res;
    logic [1:0]         idx;
    logic [15:0]        raw;
    logic signed [31:0] scaled;
    bit                 is_s20;
    if (byte_cnt < 4'd9) pad[byte_cnt] = b;
    crc_acc = crc_step(crc_acc, b);
    if (b != 8'h00) seen_nonzero = 1;
    if (byte_cnt != 4'd15) byte_cnt++;
    if (!last) return;
    exp_r = '0;
    exp_r.status = ST_OK;
    if (!pres || !seen_nonzero) begin
      exp_r.status = ST_CONNECT;
    end else if (byte_cnt != 4'd9 || crc_acc != 8'h00) begin
      exp_r.status = ST_CHECKSUM;
    end else if (!(fam inside {FAM_S20, FAM_B20, FAM_1822, FAM_1825})) begin
      exp_r.status = ST_FAMILY;
    end else begin
      is_s20 = (fam == FAM_S20);
      res = is_s20 ? 9 : (req < 8'd9 ? 9 : (req > 8'd12 ? 12 : int'(req)));
      idx = 2'(res - 9);
      exp_r.cfg_code = 8'h1F | (8'(idx) << 5);
      exp_r.rewrite = !is_s20 && (pad[4] != exp_r.cfg_code);
      raw = {pad[1], pad[0]};
      if (is_s20) begin
        raw = raw << 3;
        // count registers refine the half-degree reading, wrap kept mod 2^16
        if (pad[7] == COUNTS_PER_DEG)
          raw = (raw & S20_INT_MASK) + S20_BIAS - {8'h00, pad[6]};
      end else begin
        raw = raw & ~(16'h0007 >> idx);
      end
      scaled = $signed(raw) * 32'sd625;
      exp_r.temperature = scaled[25:0];
    end
    expected_frames.push_back(exp_r);
    crc_acc = 8'h00;
    seen_nonzero = 0;
    byte_cnt = 4'd0;
  endfunction

  function void check_frame(logic [1:0] status, logic signed [25:0] temperature,
                            logic rewrite, logic [7:0] cfg_code);
    decoded_t exp_r;
    if (expected_frames.size() == 0) begin
      unexpected++;
      $display("unexpected result: status %0d temperature %0d", status, temperature);
      return;
    end
    exp_r = expected_frames.pop_front();
    frames_checked++;
    status_seen[exp_r.status]++;
    if (status !== exp_r.status || temperature !== exp_r.temperature ||
        rewrite !== exp_r.rewrite || cfg_code !== exp_r.cfg_code) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on frame %0d: status %0d/%0d temperature %0d/%0d (exp/got)",
                 frames_checked, exp_r.status, status, exp_r.temperature, temperature);
        $display("  rewrite %0b/%0b code %02h/%02h (exp/got)", exp_r.rewrite, rewrite,
                 exp_r.cfg_code, cfg_code);
      end
    end
  endfunction
endclass

module tb_ds18x20_scratchpad_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int BYTE_TARGET    = 1550;

  logic clk = 1'b0;
  logic rst_n;

  dsd_in_if  in_ch ();
  dsd_out_if out_ch ();

  ds18x20_scratchpad_decoder_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  scratch_check sb;
  logic [7:0]   frame_buf [18];
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  bit           quiet = 0;
  bit           hold_req = 0;

  always #5 clk = ~clk;

  // most stalls short, a few long
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] fam,
                           input logic [7:0] req, input logic pres);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 70) ? 0 : stall_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.scratch_byte <= b;
    in_ch.last_byte    <= last;
    in_ch.family_code  <= fam;
    in_ch.resolution   <= req;
    in_ch.presence_ok  <= pres;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, last, fam, req, pres);
    bytes_sent++;
  endtask

  // non-final beats carry random side fields, the block ignores them
  task automatic send_frame(input int len, input logic [7:0] fam, input logic [7:0] req,
                            input logic pres);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_byte(frame_buf[i], 1'b1, fam, req, pres);
      else send_byte(frame_buf[i], 1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic fill_frame(input logic [7:0] lsb, input logic [7:0] msb,
                            input logic [7:0] cfg, input logic [7:0] remain,
                            input logic [7:0] per_c);
    logic [7:0] c;
    frame_buf[0] = lsb;
    frame_buf[1] = msb;
    frame_buf[2] = 8'($urandom);
    frame_buf[3] = 8'($urandom);
    frame_buf[4] = cfg;
    frame_buf[5] = 8'($urandom);
    frame_buf[6] = remain;
    frame_buf[7] = per_c;
    c = 8'h00;
    for (int i = 0; i < 8; i++) c = sb.crc_step(c, frame_buf[i]);
    frame_buf[8] = c;
  endtask

  task automatic random_frame();
    int         r;
    int         len;
    int         res;
    logic [7:0] fam;
    logic [7:0] req;
    logic [7:0] lsb;
    logic [7:0] msb;
    logic [7:0] cfg;
    logic [7:0] per_c;
    logic       pres;
    r = $urandom_range(0, 99);
    if (r < 20) fam = FAM_S20;
    else if (r < 40) fam = FAM_B20;
    else if (r < 55) fam = FAM_1822;
    else if (r < 70) fam = FAM_1825;
    else fam = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50) req = 8'($urandom_range(9, 12));
    else if (r < 70) req = 8'($urandom_range(0, 8));
    else if (r < 90) req = 8'($urandom_range(13, 255));
    else req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    {msb, lsb} = 16'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0: {msb, lsb} = 16'h0000;
        1: {msb, lsb} = 16'h7FFF;
        2: {msb, lsb} = 16'h8000;
        3: {msb, lsb} = 16'hFFFF;
        default: {msb, lsb} = 16'h0001;
      endcase
    end
    res = req < 8'd9 ? 9 : (req > 8'd12 ? 12 : int'(req));
    cfg = $urandom_range(0, 1) ? (8'h1F | (8'(res - 9) << 5)) : 8'($urandom);
    per_c = ($urandom_range(0, 99) < 50) ? COUNTS_PER_DEG : 8'($urandom);
    fill_frame(lsb, msb, cfg, 8'($urandom), per_c);
    len = 9;
    pres = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 78) begin
    end else if (r < 84) begin
      len = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(10, 18);
      for (int i = 9; i < len; i++) frame_buf[i] = 8'($urandom);
    end else if (r < 90) begin
      frame_buf[$urandom_range(0, 8)] ^= 8'h01 << $urandom_range(0, 7);
    end else if (r < 95) begin
      pres = 1'b0;
    end else begin
      for (int i = 0; i < 9; i++) frame_buf[i] = 8'h00;
    end
    send_frame(len, fam, req, pres);
  endtask

  // result side: checks each beat, stalls at random, one long hold-off on request
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_frame(out_ch.status, out_ch.temperature, out_ch.rewrite_config,
                       out_ch.config_code);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 75) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_left = stall_len() - 1;
        out_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int frames;
    int errors;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.scratch_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    in_ch.family_code = 8'h00;
    in_ch.resolution = 8'h00;
    in_ch.presence_ok = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // hottest reading, no rewrite needed
    fill_frame(8'hFF, 8'h7F, 8'h7F, 8'($urandom), 8'($urandom));
    send_frame(9, FAM_B20, 8'd12, 1'b1);
    // coldest reading, resolution clamped up to 9, config must be rewritten
    fill_frame(8'h00, 8'h80, 8'h00, 8'($urandom), 8'($urandom));
    send_frame(9, FAM_1822, 8'd0, 1'b1);
    // 9-bit family with count correction that wraps
    fill_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, COUNTS_PER_DEG);
    send_frame(9, FAM_S20, 8'd200, 1'b1);
    // no presence on a lone byte, then a short frame
    frame_buf[0] = 8'h5A;
    send_frame(1, FAM_1825, 8'd255, 1'b0);
    frame_buf[0] = 8'h01;
    frame_buf[1] = 8'h02;
    send_frame(2, FAM_B20, 8'd10, 1'b1);

    frames = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (frames % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (frames == 50) hold_req = 1;
      random_frame();
      frames++;
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    errors = sb.mismatches + sb.unexpected + sb.expected_frames.size();
    if (sb.mismatches > 10) $display("%0d further mismatches not shown", sb.mismatches - 10);
    $display("%0d frames from %0d bytes: %0d ok, %0d connect, %0d checksum, %0d family",
             sb.frames_checked, bytes_sent, sb.status_seen[ST_OK], sb.status_seen[ST_CONNECT],
             sb.status_seen[ST_CHECKSUM], sb.status_seen[ST_FAMILY]);
    $display("mixed clean and corrupted frames with random stalls and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
